[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
// Standalone; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2cs_pkg.sv]
// Types and constants for the I2C master transaction sequencer.
// No dependencies.
`default_nettype none

package i2cs_pkg;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_TX    = 2'd2;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_RACK  = 3'd3;
    localparam logic [2:0] CMD_RNACK = 3'd4;
    localparam logic [2:0] CMD_STOP  = 3'd5;
    localparam logic [2:0] CMD_REQ   = 3'd6;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_NAK   = 2'd1;
    localparam logic [1:0] ERR_UNEXP = 2'd2;

    localparam logic [7:0] STATUS_MASK   = 8'hf8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NAK   = 8'h20;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NAK   = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NAK   = 8'h48;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NAK     = 8'h58;
    localparam logic [7:0] ADDR_WR_MASK  = 8'hfe;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_WSTART = 4'd1,
        PH_WADDR  = 4'd2,
        PH_WNEED  = 4'd3,
        PH_WDATA  = 4'd4,
        PH_RSTART = 4'd5,
        PH_RADDR  = 4'd6,
        PH_RACK   = 4'd7,
        PH_RNACK  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  dev_address;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  bus_status;
        logic [7:0]  bus_rx_byte;
        logic [7:0]  tx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] send_value;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic [1:0] error_class;
        logic [7:0] final_status;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/i2cs_core.sv]
// Transaction state and per-item next-state / result logic.
// Depends on i2cs_pkg.
`default_nettype none

module i2cs_core
    import i2cs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_writes_left, n_writes_left;
    logic [15:0] r_reads_left, n_reads_left;
    logic [7:0]  r_address, n_address;
    logic        r_did_write, n_did_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_writes_left <= '0;
            r_reads_left  <= '0;
            r_address     <= '0;
            r_did_write   <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_writes_left <= n_writes_left;
            r_reads_left  <= n_reads_left;
            r_address     <= n_address;
            r_did_write   <= n_did_write;
        end
    end

    logic [7:0]  st;
    logic [15:0] reads_dec;

    assign st        = i_item.bus_status & STATUS_MASK;
    assign reads_dec = r_reads_left - 16'd1;

    always_comb begin
        n_phase       = r_phase;
        n_writes_left = r_writes_left;
        n_reads_left  = r_reads_left;
        n_address     = r_address;
        n_did_write   = r_did_write;
        o_result      = '0;

        priority if (i_item.kind == KIND_BEGIN) begin
            n_address     = i_item.dev_address;
            n_writes_left = i_item.write_count;
            n_reads_left  = i_item.read_count;
            n_did_write   = (i_item.write_count != 16'd0);
            if (i_item.write_count != 16'd0) begin
                o_result.command = CMD_START;
                n_phase          = PH_WSTART;
            end else if (i_item.read_count != 16'd0) begin
                o_result.command = CMD_START;
                n_phase          = PH_RSTART;
            end else begin
                o_result.done_res = 1'b1;
                n_phase           = PH_IDLE;
            end
        end else if (i_item.kind == KIND_TX) begin
            if (r_phase == PH_WNEED) begin
                o_result.command    = CMD_SEND;
                o_result.send_value = i_item.tx_byte;
                n_writes_left       = r_writes_left - 16'd1;
                n_phase             = PH_WDATA;
            end
        end else if (i_item.kind == KIND_EVENT) begin
            unique case (r_phase)
                PH_WSTART: begin
                    if (st == ST_START) begin
                        o_result.command    = CMD_SEND;
                        o_result.send_value = r_address & ADDR_WR_MASK;
                        n_phase             = PH_WADDR;
                    end else begin
                        o_result.done_res     = 1'b1;
                        o_result.error_class  = ERR_UNEXP;
                        o_result.final_status = st;
                        n_phase               = PH_IDLE;
                    end
                end
                PH_WADDR: begin
                    if (st == ST_SLAW_ACK) begin
                        o_result.command = CMD_REQ;
                        n_phase          = PH_WNEED;
                    end else begin
                        o_result.command      = (st == ST_SLAW_NAK) ? CMD_STOP : CMD_NONE;
                        o_result.done_res     = 1'b1;
                        o_result.error_class  = (st == ST_SLAW_NAK) ? ERR_NAK : ERR_UNEXP;
                        o_result.final_status = st;
                        n_phase               = PH_IDLE;
                    end
                end
                PH_WDATA: begin
                    if (st == ST_DATA_ACK) begin
                        if (r_writes_left != 16'd0) begin
                            o_result.command = CMD_REQ;
                            n_phase          = PH_WNEED;
                        end else if (r_reads_left != 16'd0) begin
                            o_result.command = CMD_START;
                            n_phase          = PH_RSTART;
                        end else begin
                            o_result.command  = CMD_STOP;
                            o_result.done_res = 1'b1;
                            n_phase           = PH_IDLE;
                        end
                    end else begin
                        o_result.command      = (st == ST_DATA_NAK) ? CMD_STOP : CMD_NONE;
                        o_result.done_res     = 1'b1;
                        o_result.error_class  = (st == ST_DATA_NAK) ? ERR_NAK : ERR_UNEXP;
                        o_result.final_status = st;
                        n_phase               = PH_IDLE;
                    end
                end
                PH_RSTART: begin
                    if (st == (r_did_write ? ST_RSTART : ST_START)) begin
                        o_result.command    = CMD_SEND;
                        o_result.send_value = r_address | 8'h01;
                        n_phase             = PH_RADDR;
                    end else begin
                        o_result.done_res     = 1'b1;
                        o_result.error_class  = ERR_UNEXP;
                        o_result.final_status = st;
                        n_phase               = PH_IDLE;
                    end
                end
                PH_RADDR: begin
                    if (st == ST_SLAR_ACK) begin
                        if (r_reads_left > 16'd1) begin
                            o_result.command = CMD_RACK;
                            n_phase          = PH_RACK;
                        end else begin
                            o_result.command = CMD_RNACK;
                            n_phase          = PH_RNACK;
                        end
                    end else begin
                        o_result.command      = (st == ST_SLAR_NAK) ? CMD_STOP : CMD_NONE;
                        o_result.done_res     = 1'b1;
                        o_result.error_class  = (st == ST_SLAR_NAK) ? ERR_NAK : ERR_UNEXP;
                        o_result.final_status = st;
                        n_phase               = PH_IDLE;
                    end
                end
                PH_RACK: begin
                    if (st == ST_RX_ACK) begin
                        o_result.rx_valid = 1'b1;
                        o_result.rx_data  = i_item.bus_rx_byte;
                        n_reads_left      = reads_dec;
                        if (reads_dec > 16'd1) begin
                            o_result.command = CMD_RACK;
                            n_phase          = PH_RACK;
                        end else begin
                            o_result.command = CMD_RNACK;
                            n_phase          = PH_RNACK;
                        end
                    end else begin
                        o_result.done_res     = 1'b1;
                        o_result.error_class  = ERR_UNEXP;
                        o_result.final_status = st;
                        n_phase               = PH_IDLE;
                    end
                end
                PH_RNACK: begin
                    if (st == ST_RX_NAK) begin
                        o_result.rx_valid = 1'b1;
                        o_result.rx_data  = i_item.bus_rx_byte;
                        o_result.command  = CMD_STOP;
                        o_result.done_res = 1'b1;
                        n_reads_left      = '0;
                        n_phase           = PH_IDLE;
                    end else begin
                        o_result.done_res     = 1'b1;
                        o_result.error_class  = ERR_UNEXP;
                        o_result.final_status = st;
                        n_phase               = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end else begin
        end
    end

endmodule

`default_nettype wire

[rtl/i2c_master_transaction_sequencer_top.sv]
// Top level of the I2C master transaction sequencer: input and result registers.
// Depends on i2cs_pkg, i2cs_core and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries begin items,
//   bus status events and supplied transmit bytes. Output channel
//   (o_out_valid / i_out_stall / o_out_item) returns exactly one result item
//   per input item, in order: the next bus command, any received byte, and
//   the done flag with error class and ending status.
//   An accepted item waits in the input register; the combinational
//   sequencing logic between it and the result register produces its result.
//   Throughput: one item per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds; one more item may
//   wait in the input register, after which o_in_stall is raised.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   sequencer to idle with all counts and the held address cleared.
`default_nettype none

module i2c_master_transaction_sequencer_top
    import i2cs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

`include "assert_macros.svh"

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      fire;
    t_out_item result;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    i2cs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `ASSERT_IMPL(a_idle_result_clean, i_clk, i_rst_n,
        o_out_valid && !o_out_item.done_res,
        o_out_item.error_class == ERR_NONE && o_out_item.final_status == 8'h00,
        "error fields set on a result that does not finish")
    `ASSERT_IMPL(a_rx_cmd, i_clk, i_rst_n,
        o_out_valid && o_out_item.rx_valid,
        o_out_item.command == CMD_RACK || o_out_item.command == CMD_RNACK ||
        o_out_item.command == CMD_STOP,
        "received byte reported with an unrelated command")
    `ASSERT_IMPL(a_nak_stop, i_clk, i_rst_n,
        o_out_valid && o_out_item.error_class == ERR_NAK,
        o_out_item.command == CMD_STOP && o_out_item.done_res,
        "NAK result without STOP")
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n,
        o_in_stall,
        r_in_valid && r_out_valid && i_out_stall,
        "input stalled without a blocked result")
    `ASSERT_NEXT(a_fire_loads, i_clk, i_rst_n,
        fire,
        r_out_valid,
        "result register not loaded after an item was processed")

endmodule

`default_nettype wire

[verif/i2c_master_transaction_sequencer_top_tb.sv]
// Self-checking testbench for i2c_master_transaction_sequencer_top: directed and random
// transaction scripts, one result predicted per item, random gaps and stalls on both sides.
// Depends on i2cs_pkg and the sequencer RTL.
`default_nettype none

module i2c_master_transaction_sequencer_top_tb
    import i2cs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] READ_BIT    = 8'h01;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1800;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_queued;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_queued     queued_items[$];
    t_out_item   awaited_actions[$];
    int unsigned items_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;
    bit          quiet        = 1'b0;

    // predictor state
    t_phase      seq_phase = PH_IDLE;
    logic [15:0] wr_left   = '0;
    logic [15:0] rd_left   = '0;
    logic [7:0]  addr_q    = '0;
    logic        wrote     = 1'b0;

    i2c_master_transaction_sequencer_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_out_item finish_ok();
        t_out_item r;
        r             = '0;
        r.done_res    = 1'b1;
        r.error_class = ERR_NONE;
        seq_phase     = PH_IDLE;
        return r;
    endfunction

    function automatic t_out_item abort_on(input logic [7:0] st, input logic nak);
        t_out_item r;
        r              = '0;
        r.command      = nak ? CMD_STOP : CMD_NONE;
        r.done_res     = 1'b1;
        r.error_class  = nak ? ERR_NAK : ERR_UNEXP;
        r.final_status = st;
        seq_phase      = PH_IDLE;
        return r;
    endfunction

    function automatic logic [2:0] read_command();
        if (rd_left > 16'd1) begin
            seq_phase = PH_RACK;
            return CMD_RACK;
        end
        seq_phase = PH_RNACK;
        return CMD_RNACK;
    endfunction

    function automatic t_out_item sequence_step(input t_in_item it);
        t_out_item  r;
        logic [7:0] st;
        r  = '0;
        st = it.bus_status & STATUS_MASK;
        case (it.kind)
            KIND_BEGIN: begin
                addr_q  = it.dev_address;
                wr_left = it.write_count;
                rd_left = it.read_count;
                wrote   = (it.write_count != 16'd0);
                if (wrote) begin
                    r.command = CMD_START;
                    seq_phase = PH_WSTART;
                end else if (rd_left != 16'd0) begin
                    r.command = CMD_START;
                    seq_phase = PH_RSTART;
                end else begin
                    r = finish_ok();
                end
            end
            KIND_TX: begin
                if (seq_phase == PH_WNEED) begin
                    r.command    = CMD_SEND;
                    r.send_value = it.tx_byte;
                    wr_left      = wr_left - 16'd1;
                    seq_phase    = PH_WDATA;
                end
            end
            KIND_EVENT: begin
                case (seq_phase)
                    PH_WSTART: begin
                        if (st == ST_START) begin
                            r.command    = CMD_SEND;
                            r.send_value = addr_q & ADDR_WR_MASK;
                            seq_phase    = PH_WADDR;
                        end else begin
                            r = abort_on(st, 1'b0);
                        end
                    end
                    PH_WADDR: begin
                        if (st == ST_SLAW_ACK) begin
                            r.command = CMD_REQ;
                            seq_phase = PH_WNEED;
                        end else begin
                            r = abort_on(st, st == ST_SLAW_NAK);
                        end
                    end
                    PH_WDATA: begin
                        if (st != ST_DATA_ACK) begin
                            r = abort_on(st, st == ST_DATA_NAK);
                        end else if (wr_left != 16'd0) begin
                            r.command = CMD_REQ;
                            seq_phase = PH_WNEED;
                        end else if (rd_left != 16'd0) begin
                            r.command = CMD_START;
                            seq_phase = PH_RSTART;
                        end else begin
                            r         = finish_ok();
                            r.command = CMD_STOP;
                        end
                    end
                    PH_RSTART: begin
                        if (st == (wrote ? ST_RSTART : ST_START)) begin
                            r.command    = CMD_SEND;
                            r.send_value = addr_q | READ_BIT;
                            seq_phase    = PH_RADDR;
                        end else begin
                            r = abort_on(st, 1'b0);
                        end
                    end
                    PH_RADDR: begin
                        if (st == ST_SLAR_ACK) begin
                            r.command = read_command();
                        end else begin
                            r = abort_on(st, st == ST_SLAR_NAK);
                        end
                    end
                    PH_RACK: begin
                        if (st == ST_RX_ACK) begin
                            r.rx_valid = 1'b1;
                            r.rx_data  = it.bus_rx_byte;
                            rd_left    = rd_left - 16'd1;
                            r.command  = read_command();
                        end else begin
                            r = abort_on(st, 1'b0);
                        end
                    end
                    PH_RNACK: begin
                        if (st == ST_RX_NAK) begin
                            r          = finish_ok();
                            r.command  = CMD_STOP;
                            r.rx_valid = 1'b1;
                            r.rx_data  = it.bus_rx_byte;
                            rd_left    = '0;
                        end else begin
                            r = abort_on(st, 1'b0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // all fields random, so bits outside the kind's own fields get exercised too
    function automatic t_in_item random_item();
        t_in_item it;
        it.kind        = 2'($urandom_range(0, 3));
        it.dev_address = 8'($urandom);
        it.write_count = 16'($urandom);
        it.read_count  = 16'($urandom);
        it.bus_status  = 8'($urandom);
        it.bus_rx_byte = 8'($urandom);
        it.tx_byte     = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item begin_item(input logic [7:0] a, input logic [15:0] w,
                                            input logic [15:0] r);
        t_in_item it;
        it             = random_item();
        it.kind        = KIND_BEGIN;
        it.dev_address = a;
        it.write_count = w;
        it.read_count  = r;
        return it;
    endfunction

    function automatic t_in_item status_item(input logic [7:0] st, input logic [7:0] rx);
        t_in_item it;
        it             = random_item();
        it.kind        = KIND_EVENT;
        it.bus_status  = (st & STATUS_MASK) | 8'($urandom_range(0, 7));
        it.bus_rx_byte = rx;
        return it;
    endfunction

    function automatic t_in_item tx_item(input logic [7:0] b);
        t_in_item it;
        it         = random_item();
        it.kind    = KIND_TX;
        it.tx_byte = b;
        return it;
    endfunction

    function automatic t_in_item unused_item();
        t_in_item it;
        it      = random_item();
        it.kind = KIND_UNUSED;
        return it;
    endfunction

    function automatic void queue_item(input t_in_item it, input bit drain);
        t_queued q;
        q.item  = it;
        q.drain = drain;
        queued_items.push_back(q);
        if (it.kind != KIND_UNUSED)
            items_queued++;
    endfunction

    // Pushes the expected status (now and then after a stray item), a broken one, or nothing;
    // returns 0 when the script must stop because the transaction is over or abandoned.
    function automatic bit send_status(input logic [7:0] good, input logic [7:0] nak);
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 3) begin
            queue_item(status_item(8'($urandom), 8'($urandom)), 1'b0);
            return 1'b0;
        end
        if (k < 7) begin
            queue_item(status_item(nak, 8'($urandom)), 1'b0);
            return 1'b0;
        end
        if (k < 9)
            return 1'b0;
        if (k < 12)
            queue_item(($urandom_range(0, 1) == 0) ? unused_item() : tx_item(8'($urandom)),
                       1'b0);
        queue_item(status_item(good, 8'($urandom)), 1'b0);
        return 1'b1;
    endfunction

    function automatic void run_transaction(input bit drain);
        logic [15:0] w;
        logic [15:0] r;
        bit          big;
        big = ($urandom_range(0, 19) == 0);
        w   = big ? 16'($urandom) : 16'($urandom_range(0, 3));
        r   = big ? 16'($urandom) : 16'($urandom_range(0, 4));
        queue_item(begin_item(8'($urandom), w, r), drain);
        if (w != 16'd0) begin
            if (!send_status(ST_START, ST_SLAW_NAK))
                return;
            if (!send_status(ST_SLAW_ACK, ST_SLAW_NAK))
                return;
            for (int i = 0; i < w; i++) begin
                if (i == 6)
                    return;
                if ($urandom_range(0, 19) == 0)
                    queue_item(status_item(8'($urandom), 8'($urandom)), 1'b0);
                queue_item(tx_item(8'($urandom)), 1'b0);
                if (!send_status(ST_DATA_ACK, ST_DATA_NAK))
                    return;
            end
        end
        if (r == 16'd0)
            return;
        if (!send_status((w != 16'd0) ? ST_RSTART : ST_START, ST_SLAW_NAK))
            return;
        if (!send_status(ST_SLAR_ACK, ST_SLAR_NAK))
            return;
        for (int i = 0; i < r; i++) begin
            if (i == 6)
                return;
            if (i == r - 1) begin
                if (!send_status(ST_RX_NAK, ST_RX_ACK))
                    return;
            end else begin
                if (!send_status(ST_RX_ACK, ST_RX_NAK))
                    return;
            end
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned k;
        if ($urandom_range(0, 299) == 0)
            quiet = !quiet;
        if (quiet)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf("cmd=%0d send=%02h rxv=%0b rx=%02h done=%0b err=%0d st=%02h",
                         r.command, r.send_value, r.rx_valid, r.rx_data, r.done_res,
                         r.error_class, r.final_status);
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endfunction

    // item driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                awaited_actions.push_back(sequence_step(in_item));
            if (!in_valid || !in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (queued_items.size() != 0 &&
                             !(queued_items[0].drain && awaited_actions.size() != 0)) begin
                    in_item  <= queued_items[0].item;
                    in_valid <= 1'b1;
                    queued_items.pop_front();
                    send_gap = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (awaited_actions.size() == 0) begin
                    flag_mismatch({"result with none expected: ", show(out_item)});
                end else begin
                    want = awaited_actions.pop_front();
                    if (out_item.command !== want.command ||
                        out_item.send_value !== want.send_value ||
                        out_item.rx_valid !== want.rx_valid ||
                        out_item.rx_data !== want.rx_data ||
                        out_item.done_res !== want.done_res ||
                        out_item.error_class !== want.error_class ||
                        out_item.final_status !== want.final_status)
                        flag_mismatch({"expected ", show(want), " got ", show(out_item)});
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall  <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("i2c_master_transaction_sequencer_top_tb failed");
            $finish;
        end
    end

    initial begin
        // ignored items while idle
        queue_item(status_item(ST_START, 8'hff), 1'b0);
        queue_item(tx_item(8'hff), 1'b0);
        queue_item(unused_item(), 1'b0);
        // empty transaction
        queue_item(begin_item(8'h00, 16'h0000, 16'h0000), 1'b0);
        // largest counts, address NAK
        queue_item(begin_item(8'hff, 16'hffff, 16'hffff), 1'b0);
        queue_item(status_item(ST_START, 8'h00), 1'b0);
        queue_item(status_item(ST_SLAW_NAK, 8'hff), 1'b0);
        // full write then read with repeated start; an event while waiting for a byte
        queue_item(begin_item(8'ha5, 16'd1, 16'd2), 1'b0);
        queue_item(status_item(ST_START, 8'h00), 1'b0);
        queue_item(status_item(ST_SLAW_ACK, 8'h00), 1'b0);
        queue_item(status_item(ST_DATA_ACK, 8'h00), 1'b0);
        queue_item(tx_item(8'hff), 1'b0);
        queue_item(status_item(ST_DATA_ACK, 8'h00), 1'b0);
        queue_item(status_item(ST_RSTART, 8'h00), 1'b0);
        queue_item(status_item(ST_SLAR_ACK, 8'h00), 1'b0);
        queue_item(status_item(ST_RX_ACK, 8'h00), 1'b0);
        queue_item(status_item(ST_RX_NAK, 8'hff), 1'b0);
        // read only, abandoned by a new begin, then an unexpected status
        queue_item(begin_item(8'h00, 16'd0, 16'd1), 1'b0);
        queue_item(status_item(ST_START, 8'h00), 1'b0);
        queue_item(begin_item(8'h5a, 16'd1, 16'd0), 1'b0);
        queue_item(status_item(8'h38, 8'h00), 1'b0);
        // data NAK
        queue_item(begin_item(8'h3c, 16'd2, 16'd0), 1'b0);
        queue_item(status_item(ST_START, 8'h00), 1'b0);
        queue_item(status_item(ST_SLAW_ACK, 8'h00), 1'b0);
        queue_item(tx_item(8'h00), 1'b0);
        queue_item(status_item(ST_DATA_NAK, 8'h00), 1'b0);

        items_queued = 0;
        run_transaction(1'b1);
        while (items_queued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                queue_item(($urandom_range(0, 1) == 0) ? unused_item() : random_item(), 1'b0);
            run_transaction($urandom_range(0, 49) == 0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (queued_items.size() != 0 || in_valid || awaited_actions.size() != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaited_actions.size() == 0)
            $display("i2c_master_transaction_sequencer_top_tb passed");
        else
            $display("i2c_master_transaction_sequencer_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/i2cs_pkg.sv
rtl/i2cs_core.sv
rtl/i2c_master_transaction_sequencer_top.sv
verif/i2c_master_transaction_sequencer_top_tb.sv
